// ----- design/q24_8_fixed_point_alu_defines.svh -----
// Assertion macros for the Q24.8 ALU checker
`ifndef Q24_8_FIXED_POINT_ALU_DEFINES_SVH
`define Q24_8_FIXED_POINT_ALU_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define Q24A_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("q24a: assertion failed");

// next-cycle implication
`define Q24A_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("q24a: assertion failed");

`endif

// ----- design/q24a_pkg.sv -----
package q24a_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_CMP   = 4'd4,
    CMD_MIN   = 4'd5,
    CMD_MAX   = 4'd6,
    CMD_FINT  = 4'd7,
    CMD_TINT  = 4'd8,
    CMD_FFLT  = 4'd9,
    CMD_TFLT  = 4'd10,
    CMD_INC   = 4'd11,
    CMD_DEC   = 4'd12
  } cmd_e;

  typedef struct packed {
    logic        ovf;
    logic [31:0] res;
  } sat_t;

  // sign and magnitude to saturated 32-bit word
  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.ovf = 1'b1;
        r.res = NEG_MAX;
      end else begin
        r.res = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.ovf = 1'b1;
        r.res = POS_MAX;
      end else begin
        r.res = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic sat_t sat_s64(input logic signed [63:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.res = v[31:0];
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.ovf = 1'b1;
      r.res = POS_MAX;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r.ovf = 1'b1;
      r.res = NEG_MAX;
    end
    return r;
  endfunction

endpackage

// ----- design/q24_8_fixed_point_alu.sv -----
// Q24.8 fixed-point arithmetic unit.
// Input stream s_axis: one command per transaction; tdata carries command,
// operand_a, operand_b and float_in. Output stream m_axis: exactly one
// result transaction per command, in order.
// Depth is set by the divider: one quotient bit per pipeline stage over
// 33 + FRACTION_BITS stages, plus the output register. Every other
// command rides a delay line of the same length. Throughput is one
// transaction per cycle unless the receiver stalls the output; no
// command waits on another.
// Reset clears all valid bits, the output valid included; data registers
// are not reset. When the receiver holds m_axis_tready low with a result
// waiting, the whole pipeline freezes and s_axis_tready drops in the same
// cycle; nothing is lost or repeated, and it resumes when the result goes.
module q24_8_fixed_point_alu import q24a_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[3:0], operand_a[35:4], operand_b[67:36], float_in[99:68], zero pad
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_raw[31:0], float_out[63:32], is_less[64], is_equal[65],
  // is_greater[66], overflow[67], divide_by_zero[68], zero pad
  output logic [71:0]  m_axis_tdata
);

  localparam int QW   = 33 + FRACTION_BITS;
  localparam int NSTG = QW;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [31:0]        res;
    logic [31:0]        fout;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               ovf;
    logic               dz;
    logic               done;
    logic               neg;
    logic signed [9:0]  fexp;
    logic [4:0]         sh;
    logic [63:0]        mag;
  } stg_t;

  logic [3:0]         cmd_in;
  logic signed [31:0] a_in;
  logic signed [31:0] b_in;
  logic [31:0]        fin_in;
  logic [31:0]        amag;
  logic [31:0]        bmag;
  logic signed [63:0] prod_w;
  logic               en;

  stg_t          s1_d, s2_d, s3_d, s4_d, out_d, out_q;
  stg_t          pipe_q [1:NSTG];
  logic [NSTG:1] vld_q;
  logic          out_vld_q;
  logic [QW-1:0] quo;

  assign cmd_in = s_axis_tdata[3:0];
  assign a_in   = $signed(s_axis_tdata[35:4]);
  assign b_in   = $signed(s_axis_tdata[67:36]);
  assign fin_in = s_axis_tdata[99:68];

  assign amag   = a_in[31] ? 32'd0 - a_in : a_in;
  assign bmag   = b_in[31] ? 32'd0 - b_in : b_in;
  assign prod_w = a_in * b_in;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: commands that need no later stage, product, decode
  always_comb begin
    sat_t       st;
    logic [7:0] fe;
    logic [7:0] fe_eff;
    logic [23:0] fm;
    st     = '0;
    fe     = fin_in[30:23];
    fe_eff = (fe != 8'd0) ? fe : 8'd1;
    fm     = {(fe != 8'd0), fin_in[22:0]};
    s1_d     = '0;
    s1_d.cmd = cmd_in;
    case (cmd_in)
      CMD_ADD: begin
        st = sat_s64(64'(a_in) + 64'(b_in));
        s1_d.res = st.res;
        s1_d.ovf = st.ovf;
      end
      CMD_SUB: begin
        st = sat_s64(64'(a_in) - 64'(b_in));
        s1_d.res = st.res;
        s1_d.ovf = st.ovf;
      end
      CMD_MUL: s1_d.mag = prod_w;
      CMD_DIV: begin
        if (b_in == 32'sd0) begin
          s1_d.dz   = 1'b1;
          s1_d.done = 1'b1;
          s1_d.res  = (a_in > 32'sd0) ? POS_MAX : ((a_in < 32'sd0) ? NEG_MAX : 32'd0);
        end else begin
          s1_d.neg = a_in[31] ^ b_in[31];
        end
      end
      CMD_CMP: begin
        s1_d.lt = a_in < b_in;
        s1_d.eq = a_in == b_in;
        s1_d.gt = a_in > b_in;
      end
      CMD_MIN: s1_d.res = (a_in <= b_in) ? a_in : b_in;
      CMD_MAX: s1_d.res = (a_in >= b_in) ? a_in : b_in;
      CMD_FINT: begin
        st = sat_s64(64'(a_in) <<< FRACTION_BITS);
        s1_d.res = st.res;
        s1_d.ovf = st.ovf;
      end
      CMD_TINT: s1_d.res = a_in >>> FRACTION_BITS;
      CMD_FFLT: begin
        s1_d.neg  = fin_in[31];
        s1_d.mag  = 64'(fm);
        s1_d.fexp = $signed({2'b00, fe_eff}) - 10'sd150 + 10'(FRACTION_BITS);
        if (fe == 8'hFF) begin
          s1_d.ovf  = 1'b1;
          s1_d.done = 1'b1;
          s1_d.res  = (fin_in[22:0] != 23'd0) ? 32'd0 : (fin_in[31] ? NEG_MAX : POS_MAX);
        end else if (fm == 24'd0) begin
          s1_d.done = 1'b1;
        end
      end
      CMD_TFLT: begin
        s1_d.neg = a_in[31];
        s1_d.mag = 64'(amag);
      end
      CMD_INC: begin
        st = sat_s64(64'(a_in) + 64'sd1);
        s1_d.res = st.res;
        s1_d.ovf = st.ovf;
      end
      CMD_DEC: begin
        st = sat_s64(64'(a_in) - 64'sd1);
        s1_d.res = st.res;
        s1_d.ovf = st.ovf;
      end
      default: ;
    endcase
  end

  // stage 2: product rounding, float shift, leading one search
  always_comb begin
    logic [63:0] pabs;
    logic [63:0] rnd;
    logic [63:0] t;
    logic [9:0]  nexp;
    logic [5:0]  kk;
    logic [4:0]  pos;
    pabs = '0;
    rnd  = '0;
    t    = '0;
    nexp = '0;
    kk   = '0;
    pos  = '0;
    s2_d = pipe_q[1];
    case (pipe_q[1].cmd)
      CMD_MUL: begin
        pabs = pipe_q[1].mag[63] ? 64'd0 - pipe_q[1].mag : pipe_q[1].mag;
        rnd  = pabs + (64'd1 << (FRACTION_BITS - 1));
        s2_d.mag = rnd >> FRACTION_BITS;
        s2_d.neg = pipe_q[1].mag[63];
      end
      CMD_FFLT: begin
        if (!pipe_q[1].done) begin
          nexp = 10'd0 - pipe_q[1].fexp;
          kk   = nexp[5:0] - 6'd1;
          if (pipe_q[1].fexp >= 10'sd40) begin
            s2_d.mag = 64'hFF_FFFF_FFFF;
          end else if (pipe_q[1].fexp >= 10'sd0) begin
            s2_d.mag = pipe_q[1].mag << pipe_q[1].fexp[5:0];
          end else if (pipe_q[1].fexp <= -10'sd25) begin
            s2_d.mag = '0;
          end else begin
            t = pipe_q[1].mag >> kk;
            s2_d.mag = (t + 64'd1) >> 1;
          end
        end
      end
      CMD_TFLT: begin
        for (int i = 0; i < 32; i++) begin
          if (pipe_q[1].mag[i]) begin
            pos = 5'(i);
          end
        end
        s2_d.sh = 5'd31 - pos;
      end
      default: ;
    endcase
  end

  // stage 3: saturation, normalise
  always_comb begin
    sat_t        st;
    logic [31:0] norm;
    st   = '0;
    norm = '0;
    s3_d = pipe_q[2];
    case (pipe_q[2].cmd)
      CMD_MUL: begin
        st = sat_mag(pipe_q[2].neg, pipe_q[2].mag);
        s3_d.res = st.res;
        s3_d.ovf = st.ovf;
      end
      CMD_FFLT: begin
        if (!pipe_q[2].done) begin
          st = sat_mag(pipe_q[2].neg, pipe_q[2].mag);
          s3_d.res = st.res;
          s3_d.ovf = st.ovf;
        end
      end
      CMD_TFLT: begin
        norm = pipe_q[2].mag[31:0] << pipe_q[2].sh;
        s3_d.mag = 64'(norm);
      end
      default: ;
    endcase
  end

  // stage 4: round to nearest even, pack float
  always_comb begin
    logic [31:0] norm;
    logic        rup;
    logic [24:0] mant;
    logic [7:0]  expo;
    norm = pipe_q[3].mag[31:0];
    rup  = norm[7] & ((|norm[6:0]) | norm[8]);
    mant = {1'b0, norm[31:8]} + 25'(rup);
    expo = 8'd158 - 8'(pipe_q[3].sh) - 8'(FRACTION_BITS) + 8'(mant[24]);
    s4_d = pipe_q[3];
    if (pipe_q[3].cmd == CMD_TFLT && norm != 32'd0) begin
      s4_d.fout = {pipe_q[3].neg, expo, mant[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[1] <= s1_d;
      pipe_q[2] <= s2_d;
      pipe_q[3] <= s3_d;
      pipe_q[4] <= s4_d;
      for (int k = 5; k <= NSTG; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-1:1], s_axis_tvalid};
    end
  end

  q24a_div #(
    .QW (QW)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .dvd_i ({amag, {(FRACTION_BITS + 1){1'b0}}}),
    .den_i (bmag),
    .quo_o (quo)
  );

  // quotient carries one extra fraction bit: round half away from zero
  always_comb begin
    sat_t        st;
    logic [QW:0] qr;
    qr    = ({1'b0, quo} + {{QW{1'b0}}, 1'b1}) >> 1;
    st    = sat_mag(pipe_q[NSTG].neg, 64'(qr));
    out_d = pipe_q[NSTG];
    if (pipe_q[NSTG].cmd == CMD_DIV && !pipe_q[NSTG].done) begin
      out_d.res = st.res;
      out_d.ovf = st.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NSTG];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.dz, out_q.ovf, out_q.gt, out_q.eq, out_q.lt,
                          out_q.fout, out_q.res};

endmodule

// ----- design/q24a_div.sv -----
module q24a_div import q24a_pkg::*; #(
  parameter int QW = 33 + FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] dvd_i,
  input  logic [31:0]   den_i,
  output logic [QW-1:0] quo_o
);

  // restoring divider, one quotient bit per stage
  logic [31:0]   rem_q [QW];
  logic [QW-1:0] dvd_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [31:0]   den_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stg
    logic [31:0]   rem_in;
    logic [QW-1:0] dvd_in;
    logic [QW-1:0] quo_in;
    logic [31:0]   den_in;
    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dvd_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dvd_in = dvd_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
    end

    assign trial = {rem_in, dvd_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? diff[31:0] : trial[31:0];
        dvd_q[j] <= {dvd_in[QW-2:0], 1'b0};
        quo_q[j] <= {quo_in[QW-2:0], take};
        den_q[j] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ----- design/q24a_chk.sv -----
`include "q24_8_fixed_point_alu_defines.svh"

module q24a_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [103:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);

  `Q24A_ASSERT_IMP(a_cmp_flags, m_axis_tvalid, $onehot0(m_axis_tdata[66:64]))
  `Q24A_ASSERT_IMP(a_dz_no_ovf, m_axis_tvalid && m_axis_tdata[68], !m_axis_tdata[67])
  `Q24A_ASSERT_IMP(a_flt_only, m_axis_tvalid && (m_axis_tdata[63:32] != 32'd0),
                   (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[68:64] == 5'd0))
  `Q24A_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind q24_8_fixed_point_alu q24a_chk u_q24a_chk (.*);

// ----- tb/sv/q24_8_fixed_point_alu_tb.sv -----
module q24_8_fixed_point_alu_tb;
  import q24a_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 34 + FB;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 600;
  localparam logic [3:0] CMD_BAD = 4'd13;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] fin;
  } alu_cmd_t;

  typedef struct packed {
    logic [31:0] res;
    logic [31:0] fout;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        ovf;
    logic        dz;
  } alu_res_t;

  typedef struct {
    alu_cmd_t c;
    logic     known;
    alu_res_t r;
  } vec_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;

  q24_8_fixed_point_alu u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  alu_res_t pending_results[$];
  int       n_errors;
  int       n_sent;
  int       n_got;
  int       idle_cycles;
  bit       long_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [32:0] clamp_mag(input logic neg, input logic [63:0] mag);
    // returns {ovf, word}
    if (neg) begin
      if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(64'd0 - mag)};
    end
    if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

  function automatic logic [32:0] clamp_s(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sh8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] float_to_q(input logic [31:0] f);
    logic        neg;
    logic [7:0]  e;
    logic [63:0] m;
    int          s;
    neg = f[31];
    e = f[30:23];
    m = {41'd0, f[22:0]};
    if (e == 8'hFF) begin
      if (m != 0) return {1'b1, 32'd0};
      return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    if (e != 0) m[23] = 1'b1;
    s = (e != 0 ? int'(e) : 1) - 150 + FB;
    if (m == 0) return 33'd0;
    if (s >= 0) begin
      if (s >= 40) return clamp_mag(neg, 64'hFF_FFFF_FFFF);
      return clamp_mag(neg, m << s);
    end
    if (-s >= 25) return 33'd0;
    return clamp_mag(neg, (m + (64'd1 << (-s - 1))) >> (-s));
  endfunction

  function automatic logic [31:0] q_to_float(input logic signed [31:0] raw);
    logic [63:0] mag;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    int          p;
    int          k;
    mag = abs64(64'(raw));
    if (mag == 0) return 32'd0;
    p = 31;
    while (mag[p] == 1'b0) p--;
    if (p > 23) begin
      k = p - 23;
      rem = mag & ((64'd1 << k) - 1);
      half = 64'd1 << (k - 1);
      mant = mag >> k;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end else begin
      mant = mag << (23 - p);
    end
    return {raw[31], 8'(p - FB + 127), mant[22:0]};
  endfunction

  function automatic alu_res_t predict_alu(input alu_cmd_t c);
    alu_res_t r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    logic [32:0] t;
    r = '0;
    t = '0;
    a = 64'(signed'(c.a));
    b = 64'(signed'(c.b));
    case (c.cmd)
      CMD_ADD: t = clamp_s(a + b);
      CMD_SUB: t = clamp_s(a - b);
      CMD_MUL: begin
        p = a * b;
        t = clamp_mag(p < 0, (abs64(p) + (64'd1 << (FB - 1))) >> FB);
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
          t[31:0] = a > 0 ? POS_MAX : (a < 0 ? NEG_MAX : 32'd0);
        end else begin
          num = abs64(a) << FB;
          den = abs64(b);
          t = clamp_mag((a < 0) != (b < 0), (2 * num + den) / (2 * den));
        end
      end
      CMD_CMP: begin
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
      end
      CMD_MIN: t[31:0] = a <= b ? c.a : c.b;
      CMD_MAX: t[31:0] = a >= b ? c.a : c.b;
      CMD_FINT: t = clamp_s(a <<< FB);
      CMD_TINT: t[31:0] = 32'(a >>> FB);
      CMD_FFLT: t = float_to_q(c.fin);
      CMD_TFLT: r.fout = q_to_float(c.a);
      CMD_INC: t = clamp_s(a + 1);
      CMD_DEC: t = clamp_s(a - 1);
      default: ;
    endcase
    r.res = t[31:0];
    r.ovf = t[32];
    return r;
  endfunction

  function automatic vec_t dv(input logic [3:0] cmd, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] fin);
    vec_t v;
    v.c = '{cmd, a, b, fin};
    v.known = 1'b0;
    v.r = '0;
    return v;
  endfunction

  function automatic vec_t dk(input logic [3:0] cmd, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] fin,
                              input alu_res_t r);
    vec_t v;
    v = dv(cmd, a, b, fin);
    v.known = 1'b1;
    v.r = r;
    return v;
  endfunction

  function automatic int gap_len();
    int x;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return POS_MAX - $urandom_range(0, 3);
      1: return NEG_MAX + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 2047)) - 1024);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 4))
      0: f[30:23] = 8'(120 + $urandom_range(0, 40));
      1: f[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return f;
  endfunction

  task automatic send_cmd(input alu_cmd_t c);
    s_axis_tdata <= {4'd0, c.fin, c.b, c.a, c.cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic offer(input vec_t v);
    int g;
    if (v.known) pending_results.push_back(v.r);
    else pending_results.push_back(predict_alu(v.c));
    send_cmd(v.c);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // receiver side
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 99) < 2) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 10) ? 1'b0 : 1'b1;
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    alu_res_t got;
    alu_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[64], m_axis_tdata[65],
             m_axis_tdata[66], m_axis_tdata[67], m_axis_tdata[68]};
      n_got++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.res !== exp_r.res) begin
          $error("result_raw: expected %h, actual %h", exp_r.res, got.res);
          n_errors++;
        end
        if (got.fout !== exp_r.fout) begin
          $error("float_out: expected %h, actual %h", exp_r.fout, got.fout);
          n_errors++;
        end
        if (got.lt !== exp_r.lt) begin
          $error("is_less: expected %b, actual %b", exp_r.lt, got.lt);
          n_errors++;
        end
        if (got.eq !== exp_r.eq) begin
          $error("is_equal: expected %b, actual %b", exp_r.eq, got.eq);
          n_errors++;
        end
        if (got.gt !== exp_r.gt) begin
          $error("is_greater: expected %b, actual %b", exp_r.gt, got.gt);
          n_errors++;
        end
        if (got.ovf !== exp_r.ovf) begin
          $error("overflow: expected %b, actual %b", exp_r.ovf, got.ovf);
          n_errors++;
        end
        if (got.dz !== exp_r.dz) begin
          $error("divide_by_zero: expected %b, actual %b", exp_r.dz, got.dz);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    vec_t        dir[$];
    vec_t        v;
    alu_res_t    r;
    logic [31:0] a;
    n_errors = 0;
    n_sent = 0;
    n_got = 0;
    idle_cycles = 0;
    long_hold = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    r = '0; r.res = POS_MAX; r.ovf = 1'b1;
    dir.push_back(dk(CMD_ADD, POS_MAX, 32'd1, 32'd0, r));
    r = '0; r.res = NEG_MAX; r.ovf = 1'b1;
    dir.push_back(dk(CMD_SUB, NEG_MAX, 32'd1, 32'd0, r));
    dir.push_back(dv(CMD_MUL, POS_MAX, POS_MAX, 32'd0));
    dir.push_back(dv(CMD_MUL, 32'hFFFF_FF80, 32'd1, 32'd0));
    dir.push_back(dv(CMD_MUL, NEG_MAX, 32'h0000_0100, 32'd0));
    r = '0; r.res = POS_MAX; r.dz = 1'b1;
    dir.push_back(dk(CMD_DIV, 32'd5, 32'd0, 32'd0, r));
    r = '0; r.res = NEG_MAX; r.dz = 1'b1;
    dir.push_back(dk(CMD_DIV, 32'hFFFF_FFFF, 32'd0, 32'd0, r));
    r = '0; r.dz = 1'b1;
    dir.push_back(dk(CMD_DIV, 32'd0, 32'd0, 32'd0, r));
    dir.push_back(dv(CMD_DIV, NEG_MAX, 32'hFFFF_FFFF, 32'd0));
    dir.push_back(dv(CMD_DIV, 32'd1, 32'd3, 32'd0));
    r = '0; r.lt = 1'b1;
    dir.push_back(dk(CMD_CMP, NEG_MAX, POS_MAX, 32'hFFFF_FFFF, r));
    r = '0; r.eq = 1'b1;
    dir.push_back(dk(CMD_CMP, 32'd7, 32'd7, 32'd0, r));
    dir.push_back(dv(CMD_MIN, POS_MAX, NEG_MAX, 32'd0));
    dir.push_back(dv(CMD_MAX, POS_MAX, NEG_MAX, 32'd0));
    dir.push_back(dv(CMD_FINT, 32'h0080_0000, 32'd0, 32'd0));
    dir.push_back(dv(CMD_TINT, 32'hFFFF_FFFF, 32'd0, 32'd0));
    r = '0; r.res = POS_MAX; r.ovf = 1'b1;
    dir.push_back(dk(CMD_FFLT, 32'd0, 32'd0, 32'h7F80_0000, r));
    r = '0; r.ovf = 1'b1;
    dir.push_back(dk(CMD_FFLT, 32'd0, 32'd0, 32'h7FC0_0001, r));
    dir.push_back(dv(CMD_FFLT, 32'd0, 32'd0, 32'h0000_0001));
    dir.push_back(dv(CMD_FFLT, 32'd0, 32'd0, 32'hBC00_0000));
    r = '0;
    dir.push_back(dk(CMD_TFLT, 32'd0, 32'd0, 32'd0, r));
    dir.push_back(dv(CMD_TFLT, NEG_MAX, 32'd0, 32'd0));
    dir.push_back(dv(CMD_TFLT, POS_MAX, 32'd0, 32'd0));
    r = '0; r.res = POS_MAX; r.ovf = 1'b1;
    dir.push_back(dk(CMD_INC, POS_MAX, 32'd0, 32'd0, r));
    r = '0; r.res = NEG_MAX; r.ovf = 1'b1;
    dir.push_back(dk(CMD_DEC, NEG_MAX, 32'd0, 32'd0, r));
    r = '0;
    dir.push_back(dk(CMD_BAD, POS_MAX, NEG_MAX, 32'hFFFF_FFFF, r));
    foreach (dir[i]) offer(dir[i]);

    // sender waits for the pipeline to drain
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 50) long_hold = 1'b1;
      v.known = 1'b0;
      v.r = '0;
      v.c.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                              : 4'($urandom_range(0, 12));
      a = rand_operand();
      v.c.a = a;
      v.c.b = ($urandom_range(0, 15) == 0) ? (($urandom_range(0, 1)) ? 32'd0 : a)
                                          : rand_operand();
      v.c.fin = rand_float();
      if (i < 100) begin
        // back-to-back burst so long_hold fills the pipeline
        pending_results.push_back(predict_alu(v.c));
        send_cmd(v.c);
      end else begin
        offer(v);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);
    $display("sent %0d commands (all opcodes, saturation, divide by zero, float edges)",
             n_sent);
    $display("received %0d results under random gaps and back-pressure", n_got);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
